FILE: hdl/ddwp_pkg.sv
// ----------------------------------------------------------------------------
// ddwp_pkg
// Shared types, register indexes and fixed-point helpers for the
// differential-drive wheel PID core.
// ----------------------------------------------------------------------------
`default_nettype none

package ddwp_pkg;

    typedef enum logic [2:0] {
        CFG_LIN_LIM     = 3'd0,
        CFG_ANG_LIM     = 3'd1,
        CFG_KP          = 3'd2,
        CFG_KI_DT       = 3'd3,
        CFG_KD_RATE     = 3'd4,
        CFG_WHEEL_RAD   = 3'd5,
        CFG_HALF_TRACK  = 3'd6,
        CFG_COUNT_SCALE = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS = 64;
    localparam int DEN_W = 37;

    localparam logic [14:0] RST_LIN_LIM     = 15'd1638;
    localparam logic [14:0] RST_ANG_LIM     = 15'd6144;
    localparam logic [31:0] RST_KP          = 32'd196608;
    localparam logic [31:0] RST_KI_DT       = 32'd10486;
    localparam logic [31:0] RST_KD_RATE     = 32'd0;
    localparam logic [31:0] RST_WHEEL_RAD   = 32'd2300;
    localparam logic [31:0] RST_HALF_TRACK  = 32'd7680;
    localparam logic [31:0] RST_COUNT_SCALE = 32'd142993;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // divide by 2^n, truncating toward zero
    function automatic logic signed [63:0] f_shr(input logic signed [63:0] v,
                                                 input int unsigned n);
        logic signed [63:0] r;
        if (v < 0) begin
            r = -((-v) >>> n);
        end else begin
            r = v >>> n;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] f_clamp(input logic signed [15:0] v,
                                                   input logic [14:0] lim);
        logic signed [16:0] vx;
        logic signed [16:0] lx;
        logic signed [16:0] r;
        vx = 17'(v);
        lx = $signed({2'b00, lim});
        if (vx > lx) begin
            r = lx;
        end else if (vx < -lx) begin
            r = -lx;
        end else begin
            r = vx;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/diff_drive_wheel_pid_core.sv
// One input word at a time: a new word is accepted only in idle, after the
// previous result word has been handed to the output register. Three 64-step
// restoring divides share the single divider, and all products pass through
// the one shared 32x32 multiplier.
// Reset: synchronous active-low; clears sequencer, PID state and loads
// register defaults.
// ----------------------------------------------------------------------------
// diff_drive_wheel_pid_core
// Clamps velocity commands, runs inverse kinematics, estimates wheel speed
// from encoder deltas and runs one PID per wheel on a shared mul/div unit.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_wheel_pid_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ddwp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ddwp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [15:0]             i_lin_cmd,
    input  wire logic signed [15:0]             i_ang_cmd,
    input  wire logic signed [15:0]             i_left_count,
    input  wire logic signed [15:0]             i_right_count,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [15:0]                  o_left_drive,
    output logic signed [15:0]                  o_right_drive,
    output logic signed [15:0]                  o_lin_est,
    output logic signed [15:0]                  o_ang_est
);
    import ddwp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_M_WH, S_M_ESTL, S_M_ESTR, S_DL_GO, S_DIV, S_DR_GO, S_DR_END,
        S_ERR, S_M_IL, S_M_IR, S_M_PL, S_M_DL, S_M_PR, S_M_DR, S_M_SUM,
        S_M_DIFF, S_AE_GO, S_DONE
    } t_state;

    typedef enum logic [1:0] {TAG_DL, TAG_DR, TAG_AE} t_dv_tag;

    t_state r_state;
    t_dv_tag r_dv_tag;

    logic [14:0] r_lin_lim, r_ang_lim;
    logic [31:0] r_kp, r_ki_dt, r_kd_rate, r_wheel_rad, r_half_track, r_count_scale;

    logic signed [19:0] r_vd, r_wd;
    logic signed [15:0] r_lc;
    logic signed [16:0] r_rc;
    logic signed [39:0] r_wh;
    logic signed [31:0] r_est_l, r_est_r, r_des_l, r_des_r;
    logic signed [31:0] r_e_l, r_e_r, r_d_l, r_d_r;
    logic signed [31:0] r_integ_l, r_integ_r, r_last_err_l, r_last_err_r;
    logic signed [31:0] r_last_set_l, r_last_set_r;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [15:0] r_drv_l, r_drv_r, r_lin;
    logic r_o_valid;

    logic [63:0]      r_dv_num;
    logic [DEN_W-1:0] r_dv_rem;
    logic [DEN_W-1:0] r_dv_den;
    logic             r_dv_neg;
    logic [5:0]       r_dv_cnt;

    logic [31:0] w_rad, w_ht;
    logic signed [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic signed [65:0] w_prod;
    logic signed [63:0] w_q16;
    logic signed [63:0] w_div_src;
    logic [DEN_W-1:0] w_div_den;
    logic [DEN_W:0] w_rem_sh;
    logic w_qbit;
    logic signed [63:0] w_quot;
    logic signed [63:0] n_acc;

    assign w_rad = (r_wheel_rad == '0) ? 32'd1 : r_wheel_rad;
    assign w_ht = (r_half_track == '0) ? 32'd1 : r_half_track;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_M_WH: begin
                w_mul_a = 32'(r_wd);
                w_mul_b = r_half_track;
            end
            S_M_ESTL: begin
                w_mul_a = 32'(r_lc);
                w_mul_b = r_count_scale;
            end
            S_M_ESTR: begin
                w_mul_a = 32'(r_rc);
                w_mul_b = r_count_scale;
            end
            S_M_IL: begin
                w_mul_a = r_e_l;
                w_mul_b = r_ki_dt;
            end
            S_M_IR: begin
                w_mul_a = r_e_r;
                w_mul_b = r_ki_dt;
            end
            S_M_PL: begin
                w_mul_a = r_e_l;
                w_mul_b = r_kp;
            end
            S_M_DL: begin
                w_mul_a = r_d_l;
                w_mul_b = r_kd_rate;
            end
            S_M_PR: begin
                w_mul_a = r_e_r;
                w_mul_b = r_kp;
            end
            S_M_DR: begin
                w_mul_a = r_d_r;
                w_mul_b = r_kd_rate;
            end
            S_M_SUM: begin
                w_mul_a = f_sat32(64'(r_est_r) + 64'(r_est_l));
                w_mul_b = w_rad;
            end
            S_M_DIFF: begin
                w_mul_a = f_sat32(64'(r_est_r) - 64'(r_est_l));
                w_mul_b = w_rad;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = 66'(w_mul_a) * 66'($signed({1'b0, w_mul_b}));
    assign w_q16 = f_shr(r_prod, 16);
    assign n_acc = r_acc + w_q16;

    // divider launch operands
    always_comb begin
        w_div_src = r_prod;
        w_div_den = {w_ht, 5'b0};
        case (r_state)
            S_DL_GO: begin
                w_div_src = (64'(r_vd) - 64'(r_wh)) <<< 16;
                w_div_den = DEN_W'(w_rad);
            end
            S_DR_GO: begin
                w_div_src = (64'(r_vd) + 64'(r_wh)) <<< 16;
                w_div_den = DEN_W'(w_rad);
            end
            default: begin
                w_div_src = r_prod;
                w_div_den = {w_ht, 5'b0};
            end
        endcase
    end

    assign w_rem_sh = {r_dv_rem, r_dv_num[63]};
    assign w_qbit = (w_rem_sh >= {1'b0, r_dv_den});
    assign w_quot = r_dv_neg ? -$signed(r_dv_num) : $signed(r_dv_num);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_valid <= 1'b0;
            r_lin_lim <= RST_LIN_LIM;
            r_ang_lim <= RST_ANG_LIM;
            r_kp <= RST_KP;
            r_ki_dt <= RST_KI_DT;
            r_kd_rate <= RST_KD_RATE;
            r_wheel_rad <= RST_WHEEL_RAD;
            r_half_track <= RST_HALF_TRACK;
            r_count_scale <= RST_COUNT_SCALE;
            r_integ_l <= '0;
            r_integ_r <= '0;
            r_last_err_l <= '0;
            r_last_err_r <= '0;
            r_last_set_l <= '0;
            r_last_set_r <= '0;
            r_dv_tag <= TAG_DL;
            r_dv_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LIN_LIM:     r_lin_lim <= i_cfg_data[14:0];
                    CFG_ANG_LIM:     r_ang_lim <= i_cfg_data[14:0];
                    CFG_KP:          r_kp <= i_cfg_data;
                    CFG_KI_DT:       r_ki_dt <= i_cfg_data;
                    CFG_KD_RATE:     r_kd_rate <= i_cfg_data;
                    CFG_WHEEL_RAD:   r_wheel_rad <= i_cfg_data;
                    CFG_HALF_TRACK:  r_half_track <= i_cfg_data;
                    CFG_COUNT_SCALE: r_count_scale <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_o_valid && i_out_ready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end

            r_prod <= w_prod[63:0];

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_vd <= {f_clamp(i_lin_cmd, r_lin_lim), 4'b0};
                        r_wd <= {f_clamp(i_ang_cmd, r_ang_lim), 4'b0};
                        r_lc <= i_left_count;
                        r_rc <= -17'(i_right_count);
                        r_state <= S_M_WH;
                    end
                end
                S_M_WH: r_state <= S_M_ESTL;
                S_M_ESTL: begin
                    r_wh <= w_q16[39:0];
                    r_state <= S_M_ESTR;
                end
                S_M_ESTR: begin
                    r_est_l <= f_sat32(r_prod);
                    r_state <= S_DL_GO;
                end
                S_DL_GO, S_DR_GO, S_AE_GO: begin
                    r_dv_neg <= w_div_src[63];
                    r_dv_num <= w_div_src[63] ? 64'(-w_div_src) : 64'(w_div_src);
                    r_dv_den <= w_div_den;
                    r_dv_rem <= '0;
                    r_dv_cnt <= '0;
                    r_state <= S_DIV;
                    if (r_state == S_DL_GO) begin
                        r_est_r <= f_sat32(r_prod);
                        r_dv_tag <= TAG_DL;
                    end else if (r_state == S_DR_GO) begin
                        r_des_l <= f_sat32(w_quot);
                        r_dv_tag <= TAG_DR;
                    end else begin
                        r_dv_tag <= TAG_AE;
                    end
                end
                S_DIV: begin
                    r_dv_rem <= w_qbit ? DEN_W'(w_rem_sh - {1'b0, r_dv_den})
                                       : w_rem_sh[DEN_W-1:0];
                    r_dv_num <= {r_dv_num[62:0], w_qbit};
                    r_dv_cnt <= r_dv_cnt + 6'd1;
                    if (r_dv_cnt == 6'(DIV_STEPS - 1)) begin
                        case (r_dv_tag)
                            TAG_DL:  r_state <= S_DR_GO;
                            TAG_DR:  r_state <= S_DR_END;
                            TAG_AE:  r_state <= S_DONE;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DR_END: begin
                    r_des_r <= f_sat32(w_quot);
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_e_l <= f_sat32(64'(r_des_l) - 64'(r_est_l));
                    r_e_r <= f_sat32(64'(r_est_r) - 64'(r_des_r));
                    if (r_des_l != r_last_set_l || r_des_r != r_last_set_r) begin
                        r_integ_l <= '0;
                        r_integ_r <= '0;
                    end
                    r_last_set_l <= r_des_l;
                    r_last_set_r <= r_des_r;
                    r_state <= S_M_IL;
                end
                S_M_IL: begin
                    r_d_l <= f_sat32(64'(r_e_l) - 64'(r_last_err_l));
                    r_d_r <= f_sat32(64'(r_e_r) - 64'(r_last_err_r));
                    r_last_err_l <= r_e_l;
                    r_last_err_r <= r_e_r;
                    r_state <= S_M_IR;
                end
                S_M_IR: begin
                    r_integ_l <= f_sat32(64'(r_integ_l) + w_q16);
                    r_state <= S_M_PL;
                end
                S_M_PL: begin
                    r_integ_r <= f_sat32(64'(r_integ_r) + w_q16);
                    r_state <= S_M_DL;
                end
                S_M_DL: begin
                    r_acc <= w_q16 + 64'(r_integ_l);
                    r_state <= S_M_PR;
                end
                S_M_PR: begin
                    r_drv_l <= f_sat16(f_shr(n_acc, 16));
                    r_state <= S_M_DR;
                end
                S_M_DR: begin
                    r_acc <= w_q16 + 64'(r_integ_r);
                    r_state <= S_M_SUM;
                end
                S_M_SUM: begin
                    r_drv_r <= f_sat16(f_shr(n_acc, 16));
                    r_state <= S_M_DIFF;
                end
                S_M_DIFF: begin
                    r_lin <= f_sat16(f_shr(r_prod, 21));
                    r_state <= S_AE_GO;
                end
                S_DONE: begin
                    if (!r_o_valid || i_out_ready) begin
                        o_left_drive <= r_drv_l;
                        o_right_drive <= r_drv_r;
                        o_lin_est <= r_lin;
                        o_ang_est <= f_sat16(w_quot);
                        r_o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ddwp_chk.sv
// ----------------------------------------------------------------------------
// ddwp_chk
// Port-level checks for the wheel PID core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwp_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [15:0] o_left_drive,
    input wire logic signed [15:0] o_right_drive,
    input wire logic signed [15:0] o_lin_est,
    input wire logic signed [15:0] o_ang_est
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("core not idle after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input word taken while busy");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result word too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_left_drive)
            && $stable(o_right_drive) && $stable(o_lin_est) && $stable(o_ang_est))
        else $error("stalled result word changed");

endmodule

bind diff_drive_wheel_pid_core ddwp_chk u_ddwp_chk (.*);

`default_nettype wire

FILE: sim/diff_drive_wheel_pid_core_tb.sv
// ----------------------------------------------------------------------------
// diff_drive_wheel_pid_core_tb
// Self-checking bench for the wheel PID core. A queue-fed driver offers
// command/encoder words and a monitor takes drive and estimate words. Each
// accepted word is scored against a fixed-point model of the controller
// that the bench keeps itself. The run goes through several register
// settings, limits and geometry extremes among them, with random stalls
// on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_wheel_pid_core_tb;
    import ddwp_pkg::*;

    typedef struct packed {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        logic signed [15:0] lcnt;
        logic signed [15:0] rcnt;
    } t_tick;

    typedef struct packed {
        logic signed [15:0] ldrv;
        logic signed [15:0] rdrv;
        logic signed [15:0] lin_v;
        logic signed [15:0] ang_v;
    } t_drive;

    localparam int WATCHDOG = 20000;
    localparam int HOLD_CYCLES = 900;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [15:0] i_lin_cmd, i_ang_cmd, i_left_count, i_right_count;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [15:0] o_left_drive, o_right_drive, o_lin_est, o_ang_est;

    diff_drive_wheel_pid_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_lin_cmd     (i_lin_cmd),
        .i_ang_cmd     (i_ang_cmd),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive),
        .o_lin_est     (o_lin_est),
        .o_ang_est     (o_ang_est)
    );

    // controller copy: registers and loop state
    longint lin_lim, ang_lim, kp, ki_dt, kd_rate, wheel_r, half_tr, cnt_scale;
    longint integ_l, integ_r, prev_err_l, prev_err_r, prev_set_l, prev_set_r;

    t_tick  tick_q[$];
    t_drive drive_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int idle_cnt = 0;
    bit calm = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_left = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint clamp_cmd(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint gain_mul(longint a, longint g);
        return (a * g) / 65536;
    endfunction

    function automatic longint wheel_loop(longint e, ref longint integ, ref longint prev_e);
        longint d, s;
        integ = sat32(integ + gain_mul(e, ki_dt));
        d = sat32(e - prev_e);
        s = gain_mul(e, kp) + integ + gain_mul(d, kd_rate);
        prev_e = e;
        return sat16(s / 65536);
    endfunction

    function automatic t_drive control_tick(t_tick t);
        t_drive r;
        longint rad, ht, vd, wd, wh, des_l, des_r, est_l, est_r;
        rad = (wheel_r != 0) ? wheel_r : 1;
        ht = (half_tr != 0) ? half_tr : 1;
        vd = clamp_cmd(longint'(t.lin), lin_lim) * 16;
        wd = clamp_cmd(longint'(t.ang), ang_lim) * 16;
        wh = gain_mul(wd, half_tr);
        des_l = sat32(((vd - wh) * 65536) / rad);
        des_r = sat32(((vd + wh) * 65536) / rad);
        est_l = sat32(longint'(t.lcnt) * cnt_scale);
        est_r = sat32(-longint'(t.rcnt) * cnt_scale);
        if (des_l != prev_set_l || des_r != prev_set_r) begin
            integ_l = 0;
            integ_r = 0;
        end
        r.ldrv = 16'(wheel_loop(sat32(des_l - est_l), integ_l, prev_err_l));
        r.rdrv = 16'(wheel_loop(sat32(est_r - des_r), integ_r, prev_err_r));
        prev_set_l = des_l;
        prev_set_r = des_r;
        r.lin_v = 16'(sat16((sat32(est_r + est_l) * rad) / 2097152));
        r.ang_v = 16'(sat16((sat32(est_r - est_l) * rad) / (ht * 32)));
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        t_tick nxt;
        logic  v;
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            v = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                drive_q.push_back(control_tick({i_lin_cmd, i_ang_cmd,
                                                i_left_count, i_right_count}));
                n_sent++;
                v = 0;
            end
            if (!v && tick_q.size() > 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                nxt = tick_q.pop_front();
                i_lin_cmd <= nxt.lin;
                i_ang_cmd <= nxt.ang;
                i_left_count <= nxt.lcnt;
                i_right_count <= nxt.rcnt;
                v = 1;
            end
            i_in_valid <= v;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_drive exp_w;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                if (drive_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word exp none act %h %h %h %h", $time,
                             o_left_drive, o_right_drive, o_lin_est, o_ang_est);
                end else begin
                    exp_w = drive_q.pop_front();
                    if (o_left_drive !== exp_w.ldrv) begin
                        errors++;
                        $display("%0t: left_drive exp %0d act %0d", $time,
                                 exp_w.ldrv, o_left_drive);
                    end
                    if (o_right_drive !== exp_w.rdrv) begin
                        errors++;
                        $display("%0t: right_drive exp %0d act %0d", $time,
                                 exp_w.rdrv, o_right_drive);
                    end
                    if (o_lin_est !== exp_w.lin_v) begin
                        errors++;
                        $display("%0t: lin_est exp %0d act %0d", $time,
                                 exp_w.lin_v, o_lin_est);
                    end
                    if (o_ang_est !== exp_w.ang_v) begin
                        errors++;
                        $display("%0t: ang_est exp %0d act %0d", $time,
                                 exp_w.ang_v, o_ang_est);
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                i_out_ready <= 0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (tick_q.size() == 0 && drive_q.size() == 0 && !i_in_valid)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LIN_LIM:     lin_lim = longint'(val[14:0]);
            CFG_ANG_LIM:     ang_lim = longint'(val[14:0]);
            CFG_KP:          kp = longint'(val);
            CFG_KI_DT:       ki_dt = longint'(val);
            CFG_KD_RATE:     kd_rate = longint'(val);
            CFG_WHEEL_RAD:   wheel_r = longint'(val);
            CFG_HALF_TRACK:  half_tr = longint'(val);
            CFG_COUNT_SCALE: cnt_scale = longint'(val);
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [31:0] ll, logic [31:0] al, logic [31:0] p,
                           logic [31:0] i, logic [31:0] d, logic [31:0] wr,
                           logic [31:0] ht, logic [31:0] cs);
        cfg_write(CFG_LIN_LIM, ll);
        cfg_write(CFG_ANG_LIM, al);
        cfg_write(CFG_KP, p);
        cfg_write(CFG_KI_DT, i);
        cfg_write(CFG_KD_RATE, d);
        cfg_write(CFG_WHEEL_RAD, wr);
        cfg_write(CFG_HALF_TRACK, ht);
        cfg_write(CFG_COUNT_SCALE, cs);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || i_in_valid || drive_q.size() > 0) @(posedge i_clk);
        repeat (220) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // runs of held commands with small or full-range encoder counts
    task automatic push_random(int n);
        t_tick t;
        int run;
        int k;
        k = 0;
        while (k < n) begin
            run = $urandom_range(1, 25);
            t.lin = ($urandom_range(0, 3) == 0) ? rnd16() : 16'($signed($urandom_range(0, 4000)) - 2000);
            t.ang = ($urandom_range(0, 3) == 0) ? rnd16() : 16'($signed($urandom_range(0, 12000)) - 6000);
            repeat (run) begin
                if ($urandom_range(0, 4) == 0) begin
                    t.lcnt = rnd16();
                    t.rcnt = rnd16();
                end else begin
                    t.lcnt = 16'($signed($urandom_range(0, 400)) - 200);
                    t.rcnt = 16'($signed($urandom_range(0, 400)) - 200);
                end
                tick_q.push_back(t);
                k++;
            end
        end
    endtask

    initial begin
        logic [15:0] edges [5];
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_out_ready = 0;
        i_lin_cmd = 0;
        i_ang_cmd = 0;
        i_left_count = 0;
        i_right_count = 0;
        lin_lim = RST_LIN_LIM; ang_lim = RST_ANG_LIM; kp = RST_KP; ki_dt = RST_KI_DT;
        kd_rate = RST_KD_RATE; wheel_r = RST_WHEEL_RAD; half_tr = RST_HALF_TRACK;
        cnt_scale = RST_COUNT_SCALE;
        integ_l = 0; integ_r = 0; prev_err_l = 0; prev_err_r = 0;
        prev_set_l = 0; prev_set_r = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: field extremes, clamping, held setpoints
        edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
        for (int j = 0; j < 5; j++)
            tick_q.push_back('{edges[j], edges[4 - j], edges[(j + 2) % 5], edges[(j + 3) % 5]});
        repeat (4) tick_q.push_back('{16'sd1000, -16'sd3000, 16'sd40, -16'sd35});
        tick_q.push_back('{16'sd9000, 16'sd9000, 16'sd0, 16'sd0});
        tick_q.push_back('{-16'sd9000, -16'sd9000, 16'sd0, 16'sd0});
        drain();

        cfg_all(32767, 32767, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, 32'hffffffff);
        for (int j = 0; j < 5; j++)
            tick_q.push_back('{edges[j], edges[(j + 1) % 5], edges[4 - j], edges[j]});
        drain();
        cfg_all(0, 0, 0, 0, 0, 32'hffffffff, 32'hffffffff, 1);
        for (int j = 0; j < 5; j++)
            tick_q.push_back('{edges[j], edges[j], edges[j], edges[4 - j]});
        drain();

        // reset-like settings; receiver holds off while the sender keeps offering
        cfg_all(1638, 6144, 196608, 10486, 0, 2300, 7680, 142993);
        push_random(300);
        hold_req = 1;
        drain();

        calm = 1;
        cfg_all(32767, 32767, 65536, 30000, 131072, 4000, 9000, 100000);
        push_random(300);
        drain();
        calm = 0;

        cfg_all(32767, 32767, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, 32'hffffffff);
        push_random(150);
        drain();

        cfg_all(20000, 100, 1000000, 500000, 70000, 0, 0, 5000);
        push_random(100);
        drain();

        for (int p = 0; p < 4; p++) begin
            cfg_all($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom,
                    $urandom_range(0, 200000), $urandom_range(0, 300000),
                    $urandom_range(1, 20000), $urandom_range(1, 40000), $urandom);
            push_random(220);
            drain();
        end

        $display("Covered %0d words across 10 register settings (limits, gains, geometry",
                 n_sent);
        $display("extremes incl. zero), with random stalls and a long receiver hold-off.");
        if (errors == 0 && drive_q.size() == 0 && n_checked == n_sent) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: diff_drive_wheel_pid_core.f
hdl/ddwp_pkg.sv
hdl/diff_drive_wheel_pid_core.sv
hdl/ddwp_chk.sv
sim/diff_drive_wheel_pid_core_tb.sv
